### rtl/core/utf8v_pkg.sv
// package for the utf8 stream validator: constants, register indexes and result type
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CAP_W              = 16;
    localparam int CFG_INDEX_W        = 8;
    localparam int CFG_DATA_W         = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_CONTROLS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY       = 8'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hffff;

    localparam logic [7:0] NUL_BYTE = 8'h00;

    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_TWO   = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR  = 2'd3;

    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] MIN_FOUR    = 21'h010000;
    localparam logic [20:0] MAX_CP      = 21'h10ffff;
    localparam logic [20:0] SURR_LO     = 21'h00d800;
    localparam logic [20:0] SURR_HI     = 21'h00dfff;
    localparam logic [20:0] C0_END      = 21'd32;
    localparam logic [20:0] C1_LO       = 21'd127;
    localparam logic [20:0] C1_HI       = 21'd159;

    typedef struct packed {
        logic             valid_res;
        logic [CAP_W-1:0] byte_count;
    } result_t;

endpackage

### rtl/core/utf8_stream_validator_top.sv
// utf8_stream_validator_top: validates a nul-terminated utf-8 byte stream
// usage:
//   s_ channel carries one string byte per transfer in s_byte_in; a zero byte
//   ends the string. each byte is decoded in the cycle it is transferred, so
//   one byte is taken per cycle while s_ready is high, with the decode and
//   count update acting on the string state registers.
//   m_ channel carries one result per string, made by the zero byte transfer:
//   m_valid_res (string well formed, no truncated sequence, length below
//   capacity) and m_byte_count (non-zero bytes, saturating at capacity).
//   the result is registered into the output buffer, behind any results still held.
//   cfg_ channel writes allow_controls (index 0) and capacity (index 1);
//   cfg_ready is always high. writes are expected only while the block idles.
//   reset (aresetn low, synchronous) clears the string state, empties the
//   result buffer and sets allow_controls to 0 and capacity to 65535.
//   a stalled receiver leaves results in a two-entry output buffer; s_ready
//   drops only when both entries are held, else bytes keep flowing.
`timescale 1ns / 1ps

module utf8_stream_validator_top
    import utf8v_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_byte_in,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_valid_res,
    output logic [CAP_W-1:0]       m_byte_count,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMP_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

    logic                  allow_reg;
    logic [CAP_W-1:0]      capacity_reg;

    logic [1:0]            pend_reg,  pend_next;
    logic [20:0]           acc_reg,   acc_next;
    logic [1:0]            class_reg, class_next;
    logic                  error_reg, error_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    result_t               head_reg, head_next;
    result_t               skid_reg, skid_next;
    logic                  head_v_reg, head_v_next;
    logic                  skid_v_reg, skid_v_next;

    logic                  in_xfer;
    logic                  is_nul;
    logic                  push;
    logic                  pop;
    result_t               new_res;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic                  below_cap;
    logic                  at_max;
    logic                  err_cnt;
    logic                  dec_bad;
    logic [20:0]           cp;
    logic [1:0]            cp_class;
    logic                  cp_check;

    function automatic logic cp_bad(input logic [20:0] c, input logic [1:0] cls,
                                    input logic allow);
        logic [20:0] minimum;
        logic        ctrl;
        case (cls)
            CLASS_TWO:   minimum = MIN_TWO;
            CLASS_THREE: minimum = MIN_THREE;
            CLASS_FOUR:  minimum = MIN_FOUR;
            default:     minimum = '0;
        endcase
        ctrl = (c < C0_END) || ((c >= C1_LO) && (c <= C1_HI));
        return (c < minimum) || (c > MAX_CP) || ((c >= SURR_LO) && (c <= SURR_HI))
               || (!allow && ctrl);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reg    <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ALLOW_CONTROLS: allow_reg    <= cfg_data[0];
                CFG_CAPACITY:       capacity_reg <= cfg_data[CAP_W-1:0];
                default:            ;
            endcase
        end
    end

    assign in_xfer   = s_valid && s_ready;
    assign is_nul    = (s_byte_in == NUL_BYTE);
    assign push      = in_xfer && is_nul;
    assign pop       = head_v_reg && m_ready;
    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(capacity_reg);
    assign below_cap = count_ext < cap_ext;
    assign at_max    = &count_reg;
    assign err_cnt   = error_reg || (below_cap && at_max);

    assign new_res.valid_res  = !error_reg && (pend_reg == 2'd0) && below_cap;
    assign new_res.byte_count = count_ext[CAP_W-1:0];

    // byte decode
    always_comb begin
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        class_next = class_reg;
        count_next = count_reg;
        error_next = error_reg;
        dec_bad    = 1'b0;
        cp         = {13'd0, s_byte_in};
        cp_class   = CLASS_NONE;
        cp_check   = 1'b0;
        if (in_xfer) begin
            if (is_nul) begin
                pend_next  = 2'd0;
                acc_next   = '0;
                class_next = CLASS_NONE;
                count_next = '0;
                error_next = 1'b0;
            end else begin
                if (below_cap && !at_max) begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
                if (!err_cnt) begin
                    if (pend_reg == 2'd0) begin
                        case (s_byte_in) inside
                            [8'h01:8'h7f]: cp_check = 1'b1;
                            [8'hc2:8'hdf]: begin
                                acc_next   = {16'd0, s_byte_in[4:0]};
                                pend_next  = 2'd1;
                                class_next = CLASS_TWO;
                            end
                            [8'he0:8'hef]: begin
                                acc_next   = {17'd0, s_byte_in[3:0]};
                                pend_next  = 2'd2;
                                class_next = CLASS_THREE;
                            end
                            [8'hf0:8'hf4]: begin
                                acc_next   = {18'd0, s_byte_in[2:0]};
                                pend_next  = 2'd3;
                                class_next = CLASS_FOUR;
                            end
                            default: dec_bad = 1'b1;
                        endcase
                    end else if (s_byte_in[7:6] != 2'b10) begin
                        dec_bad = 1'b1;
                    end else begin
                        acc_next  = {acc_reg[14:0], s_byte_in[5:0]};
                        pend_next = pend_reg - 2'd1;
                        if (pend_reg == 2'd1) begin
                            cp_check = 1'b1;
                            cp       = acc_next;
                            cp_class = class_reg;
                        end
                    end
                end
                error_next = err_cnt || dec_bad
                             || (cp_check && cp_bad(cp, cp_class, allow_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 2'd0;
            acc_reg   <= '0;
            class_reg <= CLASS_NONE;
            error_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            class_reg <= class_next;
            error_reg <= error_next;
            count_reg <= count_next;
        end
    end

    // two-entry result buffer
    always_comb begin
        head_next   = head_reg;
        skid_next   = skid_reg;
        head_v_next = head_v_reg;
        skid_v_next = skid_v_reg;
        if (pop) begin
            if (skid_v_reg) begin
                head_next   = skid_reg;
                skid_v_next = push;
                if (push) begin
                    skid_next = new_res;
                end
            end else begin
                head_v_next = push;
                if (push) begin
                    head_next = new_res;
                end
            end
        end else if (push) begin
            if (!head_v_reg) begin
                head_next   = new_res;
                head_v_next = 1'b1;
            end else begin
                skid_next   = new_res;
                skid_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign s_ready      = !skid_v_reg;
    assign m_valid      = head_v_reg;
    assign m_valid_res  = head_reg.valid_res;
    assign m_byte_count = head_reg.byte_count;

    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> head_v_reg)
        else $error("skid entry held without head entry");

    a_nul_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_byte_in == NUL_BYTE) |=> m_valid)
        else $error("no result after string end");

    a_nul_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_byte_in == NUL_BYTE)
        |=> (count_reg == '0 && !error_reg && pend_reg == 2'd0))
        else $error("string state not cleared after string end");

    a_pending_has_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd0) |-> (class_reg != CLASS_NONE))
        else $error("open sequence without length class");

endmodule
